### rtl/gpd_pkg.sv
// ============================================================================
// gpd_pkg
// Types, register codes and constants shared by the dispatcher modules.
// ============================================================================
package gpd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_MAX    = 31;
    localparam int NUM_PRIO   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 2'd2;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RST     = 5'd16;
    localparam logic [CFG_DATA_W-1:0] GROUP_COUNT_RST  = 5'd1;
    localparam logic [CFG_DATA_W-1:0] DEVICE_COUNT_RST = 5'd16;

    localparam logic [1:0] TOP_PRIORITY    = 2'd3;
    localparam logic [3:0] LONGEST_SERVICE = 4'd10;

    typedef struct packed {
        logic       action;
        logic [1:0] priority_req;
        logic [4:0] group;
        logic [3:0] service_time;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic        dispatched;
        logic [3:0]  server_index;
        logic [4:0]  sent_group;
        logic [1:0]  sent_priority;
        logic [4:0]  queue_count;
        logic [15:0] busy_mask;
    } result_t;

    typedef struct packed {
        logic cfg_we;
        logic map_start;
        logic map_step;
        logic item_load;
        logic apply;
        logic match;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic map_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [CFG_DATA_W-1:0] clamp_cfg(input logic [CFG_DATA_W-1:0] v,
                                                         input logic [CFG_DATA_W-1:0] hi);
        logic [CFG_DATA_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_DATA_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/gpd_if.sv
// ============================================================================
// gpd_if
// Valid/ready channels: request items, result items and register writes.
// ============================================================================
interface gpd_item_if import gpd_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface gpd_result_if import gpd_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface gpd_cfg_if import gpd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/grouped_priority_dispatcher.sv
// ============================================================================
// grouped_priority_dispatcher
// Priority queue of requests dispatched to the lowest idle server of a group.
// ============================================================================
// An item taken in idle passes the sequencer states apply (insert/tick), match
//   (server match) and finish (result load); finish holds while the previous
//   result is not yet taken. No new item is taken until that load is done.
// A group_count write remaps servers to groups, during which no item is taken.
// Reset: queue empty, all servers idle, capacity 16, group_count 1,
//   device_count 16; ready right after reset.
module grouped_priority_dispatcher import gpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_SERVERS = 16,
    parameter int MAX_GROUPS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    gpd_item_if.sink   req,
    gpd_result_if.source rsp,
    gpd_cfg_if.sink    cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_ready (cfg.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gpd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SERVERS (MAX_SERVERS),
        .MAX_GROUPS  (MAX_GROUPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_item  (req.item),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_item  (rsp.item)
    );

endmodule

### rtl/gpd_ctrl.sv
// ============================================================================
// gpd_ctrl
// Sequencer: item intake, queue update, server match, result hand-off,
// and the server-to-group remap after a group count write.
// ============================================================================
module gpd_ctrl import gpd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    output logic                 cfg_ready,
    input  dp_status_t           status,
    output dp_cmd_t              cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_APPLY  = 3'd1;
    localparam logic [2:0] ST_MATCH  = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_MAP    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cfg_ready  = (state_reg == ST_IDLE);
        req_ready  = (state_reg == ST_IDLE) && !cfg_valid;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_we = 1'b1;
                    if (cfg_index == REG_GROUP_COUNT)
                    begin
                        cmd.map_start = 1'b1;
                        state_next    = ST_MAP;
                    end
                end
                else if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MAP:
            begin
                cmd.map_step = 1'b1;
                if (status.map_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/gpd_datapath.sv
// ============================================================================
// gpd_datapath
// Per-priority FIFOs in one memory, server countdown timers, server group
// map, idle server search and the result register.
// ============================================================================
module gpd_datapath import gpd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_SERVERS = 16,
    parameter int MAX_GROUPS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  item_t                 req_item,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output result_t               rsp_item
);

    localparam int PW        = $clog2(QUEUE_DEPTH);
    localparam int CNTW      = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_PRIO * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SW        = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CMPW      = (CNTW > CFG_DATA_W) ? CNTW : CFG_DATA_W;

    localparam logic [CFG_DATA_W-1:0] CAP_MAX =
        CFG_DATA_W'((QUEUE_DEPTH > CFG_MAX) ? CFG_MAX : QUEUE_DEPTH);
    localparam logic [CFG_DATA_W-1:0] GC_MAX =
        CFG_DATA_W'((MAX_GROUPS > CFG_MAX) ? CFG_MAX : MAX_GROUPS);
    localparam logic [CFG_DATA_W-1:0] DC_MAX =
        CFG_DATA_W'((MAX_SERVERS > CFG_MAX) ? CFG_MAX : MAX_SERVERS);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [SW-1:0] SRV_LAST = SW'(MAX_SERVERS - 1);

    // configuration
    logic [CFG_DATA_W-1:0] cap_reg;
    logic [CFG_DATA_W-1:0] gc_reg;
    logic [CFG_DATA_W-1:0] dc_reg;

    // queue
    logic [4:0]      mem [MEM_DEPTH];
    logic [4:0]      mem_q;
    logic [PW-1:0]   rd_ptr_reg [NUM_PRIO];
    logic [PW-1:0]   wr_ptr_reg [NUM_PRIO];
    logic [CNTW-1:0] cnt_reg [NUM_PRIO];

    // servers
    logic [3:0]      remaining_reg [MAX_SERVERS];
    logic [4:0]      srv_grp_reg [MAX_SERVERS];
    logic [SW-1:0]   map_idx_reg;
    logic [4:0]      map_grp_reg;

    // per-item working state
    item_t           item_reg;
    logic            accepted_reg;
    logic [1:0]      hp_reg;
    logic            head_any_reg;
    logic            bypass_reg;
    logic [4:0]      bypass_grp_reg;
    logic            disp_reg;
    logic [SW-1:0]   srv_reg;
    logic [4:0]      sg_reg;
    logic [1:0]      sp_reg;

    logic            rsp_valid_reg;
    result_t         rsp_item_reg;

    logic [CFG_DATA_W-1:0] cap_eff;
    logic [CFG_DATA_W-1:0] gc_eff;
    logic [CFG_DATA_W-1:0] dc_eff;
    logic [CNTW-1:0]       total;
    logic                  can_store;
    logic [1:0]            p_idx;
    logic [4:0]            g_clamp;
    logic [3:0]            svc;
    logic [CNTW-1:0]       cnt_after [NUM_PRIO];
    logic [1:0]            hp;
    logic                  head_any;
    logic                  bypass;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [4:0]            head_grp;
    logic [MAX_SERVERS-1:0] mask;
    logic                  found;
    logic [SW-1:0]         sel;
    logic [15:0]           busy;

    always_comb
    begin
        cap_eff   = clamp_cfg(cap_reg, CAP_MAX);
        gc_eff    = clamp_cfg(gc_reg, GC_MAX);
        dc_eff    = clamp_cfg(dc_reg, DC_MAX);
        total     = cnt_reg[0] + cnt_reg[1] + cnt_reg[2];
        can_store = item_reg.action && (CMPW'(total) < CMPW'(cap_eff));
        p_idx     = (item_reg.priority_req == 2'd0) ? 2'd0 : item_reg.priority_req - 2'd1;
        g_clamp   = clamp_cfg(item_reg.group, gc_eff);
        if (item_reg.service_time == 4'd0)
        begin
            svc = 4'd1;
        end
        else if (item_reg.service_time > LONGEST_SERVICE)
        begin
            svc = LONGEST_SERVICE;
        end
        else
        begin
            svc = item_reg.service_time;
        end
        for (int i = 0; i < NUM_PRIO; i++)
        begin
            cnt_after[i] = cnt_reg[i] + CNTW'(can_store && (p_idx == 2'(i)));
        end
        head_any = 1'b1;
        priority if (cnt_after[2] != '0)
        begin
            hp = 2'd2;
        end
        else if (cnt_after[1] != '0)
        begin
            hp = 2'd1;
        end
        else
        begin
            hp       = 2'd0;
            head_any = (cnt_after[0] != '0);
        end
        bypass  = can_store && (p_idx == hp) && (cnt_reg[hp] == '0);
        rd_addr = AW'(hp) * AW'(QUEUE_DEPTH) + AW'(rd_ptr_reg[hp]);
        wr_addr = AW'(p_idx) * AW'(QUEUE_DEPTH) + AW'(wr_ptr_reg[p_idx]);
    end

    always_comb
    begin
        head_grp = bypass_reg ? bypass_grp_reg : mem_q;
        found    = 1'b0;
        sel      = '0;
        for (int n = 0; n < MAX_SERVERS; n++)
        begin
            mask[n] = head_any_reg && (n < int'(dc_eff)) &&
                      (srv_grp_reg[n] == head_grp) && (remaining_reg[n] == 4'd0);
        end
        for (int n = MAX_SERVERS - 1; n >= 0; n--)
        begin
            if (mask[n])
            begin
                found = 1'b1;
                sel   = SW'(n);
            end
        end
    end

    for (genvar b = 0; b < 16; b++)
    begin : g_busy
        if (b < MAX_SERVERS)
        begin : g_used
            assign busy[b] = (remaining_reg[b] != 4'd0);
        end
        else
        begin : g_none
            assign busy[b] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && can_store)
        begin
            mem[wr_addr] <= g_clamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAPACITY_RST;
            gc_reg        <= GROUP_COUNT_RST;
            dc_reg        <= DEVICE_COUNT_RST;
            map_idx_reg   <= '0;
            map_grp_reg   <= 5'd1;
            accepted_reg  <= 1'b0;
            hp_reg        <= '0;
            head_any_reg  <= 1'b0;
            bypass_reg    <= 1'b0;
            disp_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PRIO; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                cnt_reg[i]    <= '0;
            end
            for (int n = 0; n < MAX_SERVERS; n++)
            begin
                remaining_reg[n] <= 4'd0;
                srv_grp_reg[n]   <= 5'd1;
            end
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY:     cap_reg <= cfg_data;
                    REG_GROUP_COUNT:  gc_reg  <= cfg_data;
                    REG_DEVICE_COUNT: dc_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.map_start)
            begin
                map_idx_reg <= '0;
                map_grp_reg <= 5'd1;
            end
            if (cmd.map_step)
            begin
                srv_grp_reg[map_idx_reg] <= map_grp_reg;
                map_idx_reg <= (map_idx_reg == SRV_LAST) ? '0 : map_idx_reg + 1'b1;
                map_grp_reg <= (map_grp_reg == gc_eff) ? 5'd1 : map_grp_reg + 5'd1;
            end
            if (cmd.apply)
            begin
                accepted_reg <= can_store;
                hp_reg       <= hp;
                head_any_reg <= head_any;
                bypass_reg   <= bypass;
                if (can_store)
                begin
                    cnt_reg[p_idx]    <= cnt_reg[p_idx] + 1'b1;
                    wr_ptr_reg[p_idx] <= (wr_ptr_reg[p_idx] == PTR_LAST) ?
                                         '0 : wr_ptr_reg[p_idx] + 1'b1;
                end
                if (!item_reg.action)
                begin
                    for (int n = 0; n < MAX_SERVERS; n++)
                    begin
                        if (remaining_reg[n] != 4'd0)
                        begin
                            remaining_reg[n] <= remaining_reg[n] - 4'd1;
                        end
                    end
                end
            end
            if (cmd.match)
            begin
                disp_reg <= found;
                if (found)
                begin
                    remaining_reg[sel] <= svc;
                    cnt_reg[hp_reg]    <= cnt_reg[hp_reg] - 1'b1;
                    rd_ptr_reg[hp_reg] <= (rd_ptr_reg[hp_reg] == PTR_LAST) ?
                                          '0 : rd_ptr_reg[hp_reg] + 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= req_item;
        end
        if (cmd.apply)
        begin
            bypass_grp_reg <= g_clamp;
        end
        if (cmd.match)
        begin
            srv_reg <= found ? sel : '0;
            sg_reg  <= found ? head_grp : 5'd0;
            sp_reg  <= found ? 2'(hp_reg + 2'd1) : 2'd0;
        end
        if (cmd.load_out)
        begin
            rsp_item_reg.accepted      <= accepted_reg;
            rsp_item_reg.dispatched    <= disp_reg;
            rsp_item_reg.server_index  <= 4'(srv_reg);
            rsp_item_reg.sent_group    <= sg_reg;
            rsp_item_reg.sent_priority <= sp_reg;
            rsp_item_reg.queue_count   <= 5'(total);
            rsp_item_reg.busy_mask     <= busy;
        end
    end

    assign status.out_free = !rsp_valid_reg || rsp_ready;
    assign status.map_last = (map_idx_reg == SRV_LAST);
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_item        = rsp_item_reg;

endmodule

### rtl/gpd_checker.sv
// ============================================================================
// gpd_checker
// Port-level checks on the dispatcher, bound to the top level.
// ============================================================================
module gpd_checker import gpd_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input result_t rsp_item
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while previous item in work");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.dispatched |->
            rsp_item.server_index == 4'd0 && rsp_item.sent_group == 5'd0 &&
            rsp_item.sent_priority == 2'd0)
        else $error("dispatch fields set without dispatch");

    a_sent_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.dispatched |->
            rsp_item.sent_group != 5'd0 && rsp_item.sent_priority != 2'd0)
        else $error("dispatch with empty group or priority");

endmodule

bind grouped_priority_dispatcher gpd_checker u_gpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);

### tb/grouped_priority_dispatcher_tb.sv
// ============================================================================
// grouped_priority_dispatcher_tb
// Self-checking bench for the grouped priority dispatcher. Requests and ticks
// go in on the item channel and registers are set between phases. A local
// queue and server model computes the expected result of each item. The
// model covers sorted insert, drops when full, countdown, group matching and
// blocking at the head. Runs directed cases, then random traffic under three
// idling mixes and a long output stall.
// ============================================================================
module grouped_priority_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gpd_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int NSRV         = 16;
    localparam int NGRP         = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 50;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_ARRIVAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    gpd_item_if   req_ch ();
    gpd_result_if rsp_ch ();
    gpd_cfg_if    cfg_ch ();

    grouped_priority_dispatcher #(
        .QUEUE_DEPTH (QDEPTH),
        .MAX_SERVERS (NSRV),
        .MAX_GROUPS  (NGRP)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #10 clk = ~clk;

    // dispatcher model state
    logic [4:0] reg_cap;
    logic [4:0] reg_gc;
    logic [4:0] reg_dc;
    logic [1:0] q_prio [QDEPTH];
    logic [4:0] q_grp [QDEPTH];
    int         queue_len;
    logic [3:0] srv_left [NSRV];

    result_t expected_results [$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req     = 0;
    int stall_left    = 0;

    task automatic report_mismatch(input string what, input int got, input int expv);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, expv);
        end
    endtask

    function automatic int clip(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic result_t dispatch_step(input item_t it);
        result_t r;
        int      cap_e;
        int      gc_e;
        int      dc_e;
        int      svc;
        int      p;
        int      g;
        int      pos;
        int      n;
        int      k;
        bit      placed;
        r     = '0;
        cap_e = clip(reg_cap, QDEPTH);
        gc_e  = clip(reg_gc, NGRP);
        dc_e  = clip(reg_dc, NSRV);
        svc   = clip(it.service_time, LONGEST_SERVICE);
        if (it.action == ACT_ARRIVAL)
        begin
            if (queue_len < cap_e)
            begin
                p   = (it.priority_req == 2'd0) ? 1 : it.priority_req;
                g   = clip(it.group, gc_e);
                pos = 0;
                while (pos < queue_len && q_prio[pos] >= p)
                begin
                    pos++;
                end
                for (k = queue_len; k > pos; k--)
                begin
                    q_prio[k] = q_prio[k-1];
                    q_grp[k]  = q_grp[k-1];
                end
                q_prio[pos] = 2'(p);
                q_grp[pos]  = 5'(g);
                queue_len++;
                r.accepted = 1'b1;
            end
        end
        else
        begin
            for (n = 0; n < NSRV; n++)
            begin
                if (srv_left[n] != 0)
                begin
                    srv_left[n]--;
                end
            end
        end
        placed = 1'b0;
        if (queue_len > 0)
        begin
            for (n = 0; n < dc_e && !placed; n++)
            begin
                if ((n % gc_e) + 1 == q_grp[0] && srv_left[n] == 0)
                begin
                    srv_left[n]     = 4'(svc);
                    r.dispatched    = 1'b1;
                    r.server_index  = 4'(n);
                    r.sent_group    = q_grp[0];
                    r.sent_priority = q_prio[0];
                    for (k = 1; k < queue_len; k++)
                    begin
                        q_prio[k-1] = q_prio[k];
                        q_grp[k-1]  = q_grp[k];
                    end
                    queue_len--;
                    placed = 1'b1;
                end
            end
        end
        r.queue_count = 5'(queue_len);
        for (n = 0; n < NSRV; n++)
        begin
            r.busy_mask[n] = (srv_left[n] != 0);
        end
        return r;
    endfunction

    function automatic item_t mk_item(input logic act, input int prio, input int grp,
                                      input int svc);
        item_t it;
        it.action       = act;
        it.priority_req = 2'(prio);
        it.group        = 5'(grp);
        it.service_time = 4'(svc);
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    gc_e;
        gc_e            = clip(reg_gc, NGRP);
        it.action       = ($urandom_range(99) < 55) ? ACT_ARRIVAL : ACT_TICK;
        it.priority_req = 2'($urandom_range(3));
        it.group        = 5'(($urandom_range(99) < 85) ? $urandom_range(gc_e, 1)
                                                       : $urandom_range(31));
        it.service_time = 4'(($urandom_range(99) < 85) ? $urandom_range(10, 1)
                                                       : $urandom_range(15));
        return it;
    endfunction

    // valid stays high across back-to-back items; lowered only on an idle cycle or by wait_idle
    task automatic send_item(input item_t it);
        result_t exp_item;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= it;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        exp_item         = dispatch_step(it);
        expected_results = {expected_results, exp_item};
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_CAPACITY:     reg_cap = val;
            REG_GROUP_COUNT:  reg_gc  = val;
            REG_DEVICE_COUNT: reg_dc  = val;
            default:          ;
        endcase
    endtask

    // spare index written each time with junk, it must change nothing
    task automatic set_config(input int cap, input int gc, input int dc);
        wait_idle();
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(CFG_MAX)));
        write_reg(REG_CAPACITY, CFG_DATA_W'(cap));
        write_reg(REG_GROUP_COUNT, CFG_DATA_W'(gc));
        write_reg(REG_DEVICE_COUNT, CFG_DATA_W'(dc));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        wait_idle();
        send_item(mk_item(ACT_ARRIVAL, 0, 0, 0));
        send_item(mk_item(ACT_ARRIVAL, 3, 31, 15));
        send_item(mk_item(ACT_TICK, 3, 31, 15));
    endtask

    // zero and above-range register values, stale group at the head
    task automatic test_register_extremes();
        set_config(0, CFG_MAX, 0);
        send_item(mk_item(ACT_ARRIVAL, 2, 2, 5));
        send_item(mk_item(ACT_ARRIVAL, 3, 1, 5));
        send_item(mk_item(ACT_TICK, 0, 0, 15));
        set_config(CFG_MAX, CFG_MAX, CFG_MAX);
        send_item(mk_item(ACT_TICK, 0, 0, 0));
        send_item(mk_item(ACT_ARRIVAL, 0, 0, 9));
    endtask

    // one server: queued requests must leave in priority, then age, order
    task automatic test_priority_order();
        int k;
        set_config(QDEPTH, 1, 1);
        send_item(mk_item(ACT_ARRIVAL, 1, 1, 3));
        send_item(mk_item(ACT_ARRIVAL, 1, 1, 1));
        send_item(mk_item(ACT_ARRIVAL, 2, 1, 1));
        send_item(mk_item(ACT_ARRIVAL, 3, 1, 1));
        send_item(mk_item(ACT_ARRIVAL, 3, 1, 1));
        send_item(mk_item(ACT_ARRIVAL, 1, 1, 1));
        for (k = 0; k < 8; k++)
        begin
            send_item(mk_item(ACT_TICK, 0, 0, 1));
        end
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
        int done;
        int chunk;
        int k;
        int cap;
        int gc;
        int dc;
        done = 0;
        while (done < n_items)
        begin
            case ($urandom_range(4))
                0:       cap = 0;
                1:       cap = 1;
                2:       cap = CFG_MAX;
                default: cap = $urandom_range(QDEPTH, 1);
            endcase
            case ($urandom_range(4))
                0:       dc = 0;
                1:       dc = 1;
                2:       dc = CFG_MAX;
                default: dc = $urandom_range(NSRV, 1);
            endcase
            case ($urandom_range(5))
                0:       gc = 0;
                1:       gc = CFG_MAX;
                default: gc = $urandom_range(clip(dc, NSRV), 1);
            endcase
            set_config(cap, gc, dc);
            send_idle_pct = s_pct;
            recv_idle_pct = r_pct;
            chunk = $urandom_range(140, 60);
            for (k = 0; k < chunk && done < n_items; k++)
            begin
                send_item(random_item());
                done++;
            end
        end
    endtask

    // output held off long enough for the block to fill and stall its input
    task automatic test_output_stall();
        int k;
        set_config(QDEPTH, 2, 4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 300;
        for (k = 0; k < 40; k++)
        begin
            send_item(random_item());
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_req > 0)
        begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        result_t got_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_r = rsp_ch.item;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing expected, queue_count", got_r.queue_count, 0);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got_r.accepted !== exp_r.accepted)
                    report_mismatch("accepted", got_r.accepted, exp_r.accepted);
                if (got_r.dispatched !== exp_r.dispatched)
                    report_mismatch("dispatched", got_r.dispatched, exp_r.dispatched);
                if (got_r.server_index !== exp_r.server_index)
                    report_mismatch("server_index", got_r.server_index, exp_r.server_index);
                if (got_r.sent_group !== exp_r.sent_group)
                    report_mismatch("sent_group", got_r.sent_group, exp_r.sent_group);
                if (got_r.sent_priority !== exp_r.sent_priority)
                    report_mismatch("sent_priority", got_r.sent_priority, exp_r.sent_priority);
                if (got_r.queue_count !== exp_r.queue_count)
                    report_mismatch("queue_count", got_r.queue_count, exp_r.queue_count);
                if (got_r.busy_mask !== exp_r.busy_mask)
                    report_mismatch("busy_mask", got_r.busy_mask, exp_r.busy_mask);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int n;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.item  = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        reg_cap      = CAPACITY_RST;
        reg_gc       = GROUP_COUNT_RST;
        reg_dc       = DEVICE_COUNT_RST;
        queue_len    = 0;
        for (n = 0; n < QDEPTH; n++)
        begin
            q_prio[n] = '0;
            q_grp[n]  = '0;
        end
        for (n = 0; n < NSRV; n++)
        begin
            srv_left[n] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_priority_order();
        test_random_traffic(31, 79, 550);
        test_random_traffic(79, 31, 550);
        test_random_traffic(0, 0, 550);
        test_output_stall();

        wait_idle();
        repeat (20) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch("results never produced", 0, expected_results.size());
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/gpd_pkg.sv
rtl/gpd_if.sv
rtl/gpd_ctrl.sv
rtl/gpd_datapath.sv
rtl/grouped_priority_dispatcher.sv
rtl/gpd_checker.sv
tb/grouped_priority_dispatcher_tb.sv
